/* rtl/core/mfq_pkg.sv */
`default_nettype none
package mfq_pkg;

   localparam int DEF_MAX_PROCS  = 16;
   localparam int DEF_MAX_LEVELS = 8;

   localparam int PID_W  = 4;
   localparam int SVC_W  = 16;
   localparam int NLV_W  = 4;
   localparam int BASE_W = 3;
   localparam int CIDX_W = 1;
   localparam int CDAT_W = 4;
   localparam int ABS_LVL_W = 3;

   localparam logic [NLV_W-1:0]  NUM_LEVELS_RESET   = 4'd3;
   localparam logic [BASE_W-1:0] QUANTUM_BASE_RESET = 3'd2;
   localparam logic [SVC_W-1:0]  QUANTUM_MAX        = 16'hFFFF;

   typedef enum logic {
      OP_ARRIVE = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef enum logic [CIDX_W-1:0] {
      CSR_NUM_LEVELS   = 1'b0,
      CSR_QUANTUM_BASE = 1'b1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic                 found;
      logic [ABS_LVL_W-1:0] level;
      logic [SVC_W-1:0]     quantum;
   } pick_type;

   // Time slice of a level: base raised to the level, saturating at 16 bits.
   function automatic logic [SVC_W-1:0] quantum_of(input logic [ABS_LVL_W-1:0] level,
                                                    input logic [BASE_W-1:0] base);
      logic [SVC_W-1:0]        q;
      logic [SVC_W+BASE_W-1:0] p;
      logic [BASE_W-1:0]       b;
      b = (base == '0) ? BASE_W'(1) : base;
      q = SVC_W'(1);
      for (int k = 0; k < (1 << ABS_LVL_W) - 1; k++) begin
         p = q * b;
         if (k < int'(level)) begin
            q = (p > (SVC_W+BASE_W)'(QUANTUM_MAX)) ? QUANTUM_MAX : p[SVC_W-1:0];
         end
      end
      return q;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/mfq_ram.sv */
`default_nettype none
module mfq_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

/* rtl/core/mfq_pick.sv */
`default_nettype none
module mfq_pick #(
   parameter int MAX_LEVELS = mfq_pkg::DEF_MAX_LEVELS
) (
   input  wire logic [MAX_LEVELS-1:0]        nonempty,
   input  wire logic [mfq_pkg::NLV_W-1:0]    levels_used,
   input  wire logic [mfq_pkg::BASE_W-1:0]   quantum_base,
   output      mfq_pkg::pick_type            pick
);
   localparam int QIDX_W = mfq_pkg::BASE_W + mfq_pkg::ABS_LVL_W;

   // Time slices for every base and level, folded to constants at elaboration.
   logic [mfq_pkg::SVC_W-1:0] qtab [1 << QIDX_W];

   for (genvar g = 0; g < (1 << QIDX_W); g++) begin : g_qtab
      assign qtab[g] = mfq_pkg::quantum_of(mfq_pkg::ABS_LVL_W'(g),
                                           mfq_pkg::BASE_W'(g >> mfq_pkg::ABS_LVL_W));
   end

   // Lowest nonempty level in use wins.
   always_comb begin
      pick = '0;
      for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
         if (nonempty[i] && (i < int'(levels_used))) begin
            pick.found = 1'b1;
            pick.level = mfq_pkg::ABS_LVL_W'(i);
         end
      end
      pick.quantum = pick.found ? qtab[{quantum_base, pick.level}] : '0;
   end
endmodule
`default_nettype wire

/* rtl/core/multilevel_feedback_queue_scheduler.sv */
`default_nettype none
// Multilevel feedback queue scheduler.
//
// Input transactions are taken on start while busy is low. An arrival transaction
// (req_operation = arrival) queues req_process_id with req_service_time on level 0
// and gives no result; it is dropped when MAX_PROCS processes wait.
// A tick transaction runs one time unit and always gives exactly one result on the
// rsp_ ports, marked by a one-cycle rsp_valid strobe. An idle tick answers in the
// cycle after it was taken; a tick that runs a process reads the front entry of its
// queue from the entry memory, so busy is high while the read is pending and the
// result appears in the cycle in which busy drops. A running tick therefore holds
// off the next transaction while the single entry memory is read; an arrival does not.
//
// The receiver cannot stall results; each result is shown for exactly one cycle.
// Configuration transactions on the csr_ channel are always ready and are meant to
// be issued only while the block is idle. Reset clears the queue heads and counts,
// the current level and quantum, and loads the register defaults; the entry memory
// is not cleared, since only occupied entries are ever read.
module multilevel_feedback_queue_scheduler #(
   parameter int MAX_PROCS  = mfq_pkg::DEF_MAX_PROCS,
   parameter int MAX_LEVELS = mfq_pkg::DEF_MAX_LEVELS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output      logic                         busy,
   input  wire logic                         req_operation,
   input  wire logic [mfq_pkg::PID_W-1:0]    req_process_id,
   input  wire logic [mfq_pkg::SVC_W-1:0]    req_service_time,
   output      logic                         rsp_valid,
   output      logic [mfq_pkg::PID_W-1:0]    rsp_run_process,
   output      logic                         rsp_idle,
   output      logic                         rsp_finished,
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire logic [mfq_pkg::CIDX_W-1:0]   csr_index,
   input  wire logic [mfq_pkg::CDAT_W-1:0]   csr_wdata
);
   localparam int POS_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W  = $clog2(MAX_PROCS + 1);
   localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int SLOTS  = MAX_LEVELS * MAX_PROCS;
   localparam int ADDR_W = $clog2(SLOTS);
   localparam int ENT_W  = mfq_pkg::PID_W + mfq_pkg::SVC_W;
   localparam int NLV_W  = mfq_pkg::NLV_W;
   localparam int SVC_W  = mfq_pkg::SVC_W;

   // Configuration registers.
   logic [NLV_W-1:0]           num_levels_ff, num_levels_in;
   logic [mfq_pkg::BASE_W-1:0] base_ff, base_in;

   // Scheduler state.
   mfq_pkg::state_type state_ff, state_in;
   logic [POS_W-1:0]   head_ff  [MAX_LEVELS];
   logic [POS_W-1:0]   head_in  [MAX_LEVELS];
   logic [CNT_W-1:0]   count_ff [MAX_LEVELS];
   logic [CNT_W-1:0]   count_in [MAX_LEVELS];
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [LVL_W-1:0]   cur_ff, cur_in;
   logic [SVC_W-1:0]   ql_ff, ql_in;
   logic [ADDR_W-1:0]  slot_ff, slot_in;

   // Result registers.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [mfq_pkg::PID_W-1:0] rsp_pid_ff, rsp_pid_in;
   logic                      rsp_idle_ff, rsp_idle_in;
   logic                      rsp_fin_ff, rsp_fin_in;

   // Entry memory port.
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [ENT_W-1:0]  mem_wdata, mem_rdata;

   logic [NLV_W-1:0]      levels_used;
   logic [MAX_LEVELS-1:0] nonempty;
   mfq_pkg::pick_type     pick;

   function automatic logic [ADDR_W-1:0] slot_of(input logic [LVL_W-1:0] lvl,
                                                 input logic [POS_W-1:0] pos);
      return ADDR_W'(lvl) * ADDR_W'(MAX_PROCS) + ADDR_W'(pos);
   endfunction

   // Tail position: head plus count stays below twice the depth.
   function automatic logic [POS_W-1:0] tail_of(input logic [POS_W-1:0] head,
                                                input logic [CNT_W-1:0] cnt);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(head) + (CNT_W+1)'(cnt);
      if (s >= (CNT_W+1)'(MAX_PROCS)) begin
         s = s - (CNT_W+1)'(MAX_PROCS);
      end
      return s[POS_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
      return (p == POS_W'(MAX_PROCS - 1)) ? '0 : p + POS_W'(1);
   endfunction

   function automatic logic [POS_W-1:0] pos_dec(input logic [POS_W-1:0] p);
      return (p == '0) ? POS_W'(MAX_PROCS - 1) : p - POS_W'(1);
   endfunction

   assign csr_ready = 1'b1;
   assign busy      = (state_ff == mfq_pkg::ST_EXEC);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_run_process = rsp_pid_ff;
   assign rsp_idle        = rsp_idle_ff;
   assign rsp_finished    = rsp_fin_ff;

   // A level count of zero acts as one; counts above the depth are clamped.
   always_comb begin
      if (num_levels_ff == '0) begin
         levels_used = NLV_W'(1);
      end else if (num_levels_ff > NLV_W'(MAX_LEVELS)) begin
         levels_used = NLV_W'(MAX_LEVELS);
      end else begin
         levels_used = num_levels_ff;
      end
      for (int i = 0; i < MAX_LEVELS; i++) begin
         nonempty[i] = (count_ff[i] != '0);
      end
   end

   mfq_pick #(.MAX_LEVELS(MAX_LEVELS)) u_pick (
      .nonempty     (nonempty),
      .levels_used  (levels_used),
      .quantum_base (base_ff),
      .pick         (pick)
   );

   mfq_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_entries (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Configuration writes.
   always_comb begin
      num_levels_in = num_levels_ff;
      base_in       = base_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mfq_pkg::CSR_NUM_LEVELS:   num_levels_in = csr_wdata[NLV_W-1:0];
            mfq_pkg::CSR_QUANTUM_BASE: base_in = csr_wdata[mfq_pkg::BASE_W-1:0];
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mfq_pkg::ST_IDLE: begin
            if (start && req_operation == mfq_pkg::OP_TICK) begin
               if ((ql_ff != '0 && count_ff[cur_ff] != '0) || pick.found) begin
                  state_in = mfq_pkg::ST_EXEC;
               end
            end
         end
         mfq_pkg::ST_EXEC: state_in = mfq_pkg::ST_IDLE;
         default:          state_in = mfq_pkg::ST_IDLE;
      endcase
   end

   // Queue updates, memory accesses and results.
   always_comb begin
      logic [mfq_pkg::PID_W-1:0] pid;
      logic [SVC_W-1:0]          rem, new_rem, ql_dec;
      logic                      done, alone;
      logic [NLV_W-1:0]          nxt;
      logic [LVL_W-1:0]          dest;

      for (int i = 0; i < MAX_LEVELS; i++) begin
         head_in[i]  = head_ff[i];
         count_in[i] = count_ff[i];
      end
      total_in     = total_ff;
      cur_in       = cur_ff;
      ql_in        = ql_ff;
      slot_in      = slot_ff;
      rsp_valid_in = 1'b0;
      rsp_pid_in   = rsp_pid_ff;
      rsp_idle_in  = rsp_idle_ff;
      rsp_fin_in   = rsp_fin_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;

      pid     = mem_rdata[ENT_W-1:SVC_W];
      rem     = mem_rdata[SVC_W-1:0];
      done    = (rem <= SVC_W'(1));
      new_rem = done ? '0 : rem - SVC_W'(1);
      ql_dec  = ql_ff - SVC_W'(1);
      alone   = (count_ff[cur_ff] == CNT_W'(1)) && (total_ff == CNT_W'(1));
      nxt     = NLV_W'(cur_ff) + NLV_W'(1);
      dest    = (nxt >= levels_used) ? cur_ff : nxt[LVL_W-1:0];

      case (state_ff)
         mfq_pkg::ST_IDLE: begin
            if (start && req_operation == mfq_pkg::OP_ARRIVE) begin
               if (total_ff < CNT_W'(MAX_PROCS)) begin
                  mem_we    = 1'b1;
                  mem_wdata = {req_process_id, req_service_time};
                  total_in  = total_ff + CNT_W'(1);
                  if (total_ff == CNT_W'(1) && count_ff[0] == CNT_W'(1)) begin
                     // The newcomer goes ahead of the lone waiting process.
                     head_in[0]  = pos_dec(head_ff[0]);
                     count_in[0] = CNT_W'(2);
                     mem_waddr   = slot_of('0, pos_dec(head_ff[0]));
                  end else begin
                     count_in[0] = count_ff[0] + CNT_W'(1);
                     mem_waddr   = slot_of('0, tail_of(head_ff[0], count_ff[0]));
                  end
               end
            end else if (start && req_operation == mfq_pkg::OP_TICK) begin
               if (ql_ff != '0 && count_ff[cur_ff] != '0) begin
                  mem_re    = 1'b1;
                  mem_raddr = slot_of(cur_ff, head_ff[cur_ff]);
                  slot_in   = mem_raddr;
               end else if (pick.found) begin
                  cur_in    = pick.level[LVL_W-1:0];
                  ql_in     = pick.quantum;
                  mem_re    = 1'b1;
                  mem_raddr = slot_of(pick.level[LVL_W-1:0],
                                      head_ff[pick.level[LVL_W-1:0]]);
                  slot_in   = mem_raddr;
               end else begin
                  ql_in        = '0;
                  rsp_valid_in = 1'b1;
                  rsp_pid_in   = '0;
                  rsp_idle_in  = 1'b1;
                  rsp_fin_in   = 1'b0;
               end
            end
         end
         mfq_pkg::ST_EXEC: begin
            rsp_valid_in = 1'b1;
            rsp_pid_in   = pid;
            rsp_idle_in  = 1'b0;
            rsp_fin_in   = done;
            if (done) begin
               head_in[cur_ff]  = pos_inc(head_ff[cur_ff]);
               count_in[cur_ff] = count_ff[cur_ff] - CNT_W'(1);
               total_in         = total_ff - CNT_W'(1);
               cur_in           = '0;
               ql_in            = '0;
            end else begin
               ql_in     = ql_dec;
               mem_we    = 1'b1;
               mem_wdata = {pid, new_rem};
               if (ql_dec == '0 && !alone) begin
                  head_in[cur_ff] = pos_inc(head_ff[cur_ff]);
                  if (dest == cur_ff) begin
                     // Rotation on the last level: the front goes to the tail.
                     mem_waddr = slot_of(cur_ff, tail_of(head_ff[cur_ff], count_ff[cur_ff]));
                  end else begin
                     count_in[cur_ff] = count_ff[cur_ff] - CNT_W'(1);
                     count_in[dest]   = count_ff[dest] + CNT_W'(1);
                     mem_waddr        = slot_of(dest, tail_of(head_ff[dest], count_ff[dest]));
                  end
               end else begin
                  mem_waddr = slot_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mfq_pkg::ST_IDLE;
         num_levels_ff <= mfq_pkg::NUM_LEVELS_RESET;
         base_ff       <= mfq_pkg::QUANTUM_BASE_RESET;
         total_ff      <= '0;
         cur_ff        <= '0;
         ql_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         num_levels_ff <= num_levels_in;
         base_ff       <= base_in;
         total_ff      <= total_in;
         cur_ff        <= cur_in;
         ql_ff         <= ql_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            head_ff[i]  <= head_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      rsp_pid_ff <= rsp_pid_in;
      rsp_idle_ff <= rsp_idle_in;
      rsp_fin_ff <= rsp_fin_in;
   end
endmodule
`default_nettype wire

/* rtl/core/mfq_checker.sv */
`default_nettype none
module mfq_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       req_operation,
   input wire logic       rsp_valid,
   input wire logic [3:0] rsp_run_process,
   input wire logic       rsp_idle,
   input wire logic       rsp_finished
);
   // Busy covers only the memory read and is not held beyond it.
   a_busy_one: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy) else $error("busy held more than one cycle");

   // A running tick delivers its result in the cycle in which busy drops.
   a_fell_rsp: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid) else $error("missing tick result");

   // Arrivals never produce a result.
   a_arrive: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == 1'b0) |=> !rsp_valid)
      else $error("result after arrival");

   // An idle result carries no process and no completion.
   a_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_idle) |-> (rsp_run_process == 4'd0 && !rsp_finished))
      else $error("idle result carries data");
endmodule

bind multilevel_feedback_queue_scheduler mfq_checker u_mfq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_operation   (req_operation),
   .rsp_valid       (rsp_valid),
   .rsp_run_process (rsp_run_process),
   .rsp_idle        (rsp_idle),
   .rsp_finished    (rsp_finished)
);
`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPROC    = 16;
   localparam int NLEVEL   = 8;
   localparam int IDLE_LIMIT = 1000;

   // One predicted tick outcome, field for field with the rsp_ ports.
   typedef struct packed {
      logic [mfq_pkg::PID_W-1:0] run_process;
      logic                      idle;
      logic                      finished;
   } tick_outcome_type;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic                         req_operation;
   logic [mfq_pkg::PID_W-1:0]    req_process_id;
   logic [mfq_pkg::SVC_W-1:0]    req_service_time;
   logic                         rsp_valid;
   logic [mfq_pkg::PID_W-1:0]    rsp_run_process;
   logic                         rsp_idle;
   logic                         rsp_finished;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [mfq_pkg::CIDX_W-1:0]   csr_index;
   logic [mfq_pkg::CDAT_W-1:0]   csr_wdata;

   multilevel_feedback_queue_scheduler DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_process_id   (req_process_id),
      .req_service_time (req_service_time),
      .rsp_valid        (rsp_valid),
      .rsp_run_process  (rsp_run_process),
      .rsp_idle         (rsp_idle),
      .rsp_finished     (rsp_finished),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Shadow copy of the scheduler: queue slots, per-level head and count, the
   // running level and quantum, and the two configuration registers.
   logic [mfq_pkg::PID_W-1:0] sh_pid [NPROC*NLEVEL];
   logic [mfq_pkg::SVC_W-1:0] sh_rem [NPROC*NLEVEL];
   int unsigned      sh_head [NLEVEL];
   int unsigned      sh_count [NLEVEL];
   int unsigned      sh_level;
   int unsigned      sh_quantum;
   int unsigned      sh_num_levels;
   int unsigned      sh_base;

   tick_outcome_type tick_outcomes [$];
   int               mismatches;
   int               stray_results;
   int               gap_pct;
   int               idle_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned waiting_total();
      int unsigned t;
      t = 0;
      for (int i = 0; i < NLEVEL; i++) t += sh_count[i];
      return t;
   endfunction

   function automatic int unsigned slot(int unsigned lvl, int unsigned pos);
      return (lvl % NLEVEL) * NPROC + (pos % NPROC);
   endfunction

   function automatic void queue_push(int unsigned lvl, logic [mfq_pkg::PID_W-1:0] pid,
                                      logic [mfq_pkg::SVC_W-1:0] rem);
      int unsigned s;
      s = slot(lvl, sh_head[lvl] + sh_count[lvl]);
      sh_pid[s] = pid;
      sh_rem[s] = rem;
      sh_count[lvl]++;
   endfunction

   function automatic void queue_move_front(int unsigned from, int unsigned to);
      int unsigned               s;
      logic [mfq_pkg::PID_W-1:0] pid;
      logic [mfq_pkg::SVC_W-1:0] rem;
      s = slot(from, sh_head[from]);
      pid = sh_pid[s];
      rem = sh_rem[s];
      sh_head[from] = (sh_head[from] + 1) % NPROC;
      sh_count[from]--;
      queue_push(to, pid, rem);
   endfunction

   // Arrival: dropped when full; goes ahead of a lone level-0 process.
   function automatic void predict_arrival(logic [mfq_pkg::PID_W-1:0] pid,
                                           logic [mfq_pkg::SVC_W-1:0] svc);
      int unsigned total;
      bit          ahead;
      total = waiting_total();
      if (total >= NPROC) return;
      ahead = (total == 1) && (sh_count[0] == 1);
      queue_push(0, pid, svc);
      if (ahead) queue_move_front(0, 0);
   endfunction

   function automatic tick_outcome_type predict_tick();
      tick_outcome_type          o;
      int unsigned               lv, b, q, cur, s;
      bit                        found, done, alone;
      logic [mfq_pkg::SVC_W-1:0] rem;
      lv = (sh_num_levels == 0) ? 1 : (sh_num_levels > NLEVEL ? NLEVEL : sh_num_levels);
      if (sh_quantum == 0 || sh_count[sh_level % NLEVEL] == 0) begin
         sh_quantum = 0;
         found = 0;
         for (int i = 0; i < int'(lv); i++) begin
            if (!found && sh_count[i] != 0) begin
               found = 1;
               sh_level = i;
               b = (sh_base == 0) ? 1 : sh_base;
               q = 1;
               for (int k = 0; k < i; k++) begin
                  q = q * b;
                  if (q > 65535) q = 65535;
               end
               sh_quantum = q;
            end
         end
      end
      if (sh_quantum == 0) begin
         o.run_process = '0;
         o.idle = 1'b1;
         o.finished = 1'b0;
         return o;
      end
      cur = sh_level % NLEVEL;
      s = slot(cur, sh_head[cur]);
      rem = sh_rem[s];
      done = (rem <= 1);
      sh_rem[s] = done ? '0 : rem - 1'b1;
      sh_quantum--;
      o.run_process = sh_pid[s];
      o.idle = 1'b0;
      o.finished = done;
      if (done) begin
         sh_head[cur] = (sh_head[cur] + 1) % NPROC;
         sh_count[cur]--;
         sh_level = 0;
         sh_quantum = 0;
      end else if (sh_quantum == 0) begin
         // Quantum expired: demote, or rotate on the last level in use, unless it waits alone.
         alone = (sh_count[cur] == 1) && (waiting_total() == 1);
         if (!alone) begin
            if (cur + 1 >= lv) queue_move_front(cur, cur);
            else queue_move_front(cur, cur + 1);
         end
      end
      return o;
   endfunction

   // Sends one transaction and holds start until the block takes it. The
   // prediction is made at the accepting edge, ahead of any possible result.
   task automatic send_item(mfq_pkg::op_type op, logic [mfq_pkg::PID_W-1:0] pid,
                            logic [mfq_pkg::SVC_W-1:0] svc);
      start            <= 1'b1;
      req_operation    <= op;
      req_process_id   <= pid;
      req_service_time <= svc;
      do @(posedge clock); while (busy);
      if (op == mfq_pkg::OP_TICK) tick_outcomes.push_back(predict_tick());
      else predict_arrival(pid, svc);
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic tick();
      send_item(mfq_pkg::OP_TICK, mfq_pkg::PID_W'($urandom), mfq_pkg::SVC_W'($urandom));
   endtask

   task automatic arrive(int pid, int svc);
      send_item(mfq_pkg::OP_ARRIVE, mfq_pkg::PID_W'(pid), mfq_pkg::SVC_W'(svc));
   endtask

   // Lets the block drain: waits for every predicted result, then adds spare cycles, since arrivals give no result.
   task automatic drain();
      start <= 1'b0;
      while (tick_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(mfq_pkg::csr_index_type idx, int value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= mfq_pkg::CDAT_W'(value);
      do @(posedge clock); while (!csr_ready);
      if (idx == mfq_pkg::CSR_NUM_LEVELS) sh_num_levels = value & 4'hF;
      else sh_base = value & 3'h7;
      csr_valid <= 1'b0;
   endtask

   task automatic configure(int levels, int base);
      write_csr(mfq_pkg::CSR_NUM_LEVELS, levels);
      write_csr(mfq_pkg::CSR_QUANTUM_BASE, base);
   endtask

   // Result checker: every strobe must match the oldest prediction.
   always @(posedge clock) begin
      tick_outcome_type want;
      if (!reset && rsp_valid) begin
         if (tick_outcomes.size() == 0) begin
            stray_results++;
            $display("unexpected result: run=%0d idle=%0b fin=%0b",
                     rsp_run_process, rsp_idle, rsp_finished);
         end else begin
            want = tick_outcomes.pop_front();
            if (want.run_process !== rsp_run_process || want.idle !== rsp_idle ||
                want.finished !== rsp_finished) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected run=%0d idle=%0b fin=%0b, ",
                            "got run=%0d idle=%0b fin=%0b"},
                           want.run_process, want.idle, want.finished,
                           rsp_run_process, rsp_idle, rsp_finished);
            end
         end
      end
   end

   // Watchdog: any accepted transaction on any channel, or any result, restarts the count.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Extreme ids and service times, zero service, ticks on an empty block and
   // a full set of queues with arrivals past capacity being dropped.
   task automatic test_arrivals_and_overflow();
      tick();
      arrive(0, 0);
      tick();
      arrive(15, 65535);
      tick();
      tick();
      for (int i = 0; i < 17; i++) arrive(i, 1 + (i % 3));
      repeat (4) tick();
   endtask

   // Arrivals after a long run of ticks, while a single long process still waits.
   task automatic test_newcomer_ahead();
      configure(3, 2);
      repeat (40) tick();
      arrive(3, 4);
      arrive(9, 2);
      repeat (8) tick();
   endtask

   // Demoted processes stranded on levels taken out of use, then brought back.
   task automatic test_levels_out_of_use();
      configure(3, 1);
      arrive(1, 6);
      arrive(2, 6);
      repeat (4) tick();
      configure(1, 1);
      repeat (4) tick();
      configure(3, 1);
      repeat (16) tick();
   endtask

   // Register extremes, including level counts of zero and above the limit and
   // a zero base, each with a short burst of traffic.
   task automatic test_config_extremes();
      int cfgs [4][2] = '{'{0, 0}, '{15, 7}, '{8, 4}, '{1, 15}};
      for (int c = 0; c < 4; c++) begin
         configure(cfgs[c][0], cfgs[c][1]);
         arrive(5, 3);
         arrive(6, 9);
         arrive(7, 2);
         repeat (20) tick();
      end
   endtask

   // Mostly well-formed traffic with short service times so processes move
   // through the levels, plus occasional long or zero service as noise.
   task automatic test_random();
      int cfgs [5][2] = '{'{3, 2}, '{8, 4}, '{1, 1}, '{15, 0}, '{2, 3}};
      int pcts [5] = '{0, 65, 29, 65, 0};
      int svc;
      for (int p = 0; p < 5; p++) begin
         configure(cfgs[p][0], cfgs[p][1]);
         gap_pct = pcts[p];
         for (int n = 0; n < 180; n++) begin
            if ($urandom_range(99) < 65) tick();
            else begin
               case ($urandom_range(9))
                  0:       svc = $urandom_range(65535);
                  1, 2:    svc = $urandom_range(40);
                  default: svc = $urandom_range(1, 6);
               endcase
               arrive($urandom_range(15), svc);
            end
         end
      end
      gap_pct = 0;
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_operation    = mfq_pkg::OP_ARRIVE;
      req_process_id   = '0;
      req_service_time = '0;
      csr_valid        = 1'b0;
      csr_index        = mfq_pkg::CSR_NUM_LEVELS;
      csr_wdata        = '0;
      mismatches       = 0;
      stray_results    = 0;
      gap_pct          = 0;
      idle_cycles      = 0;
      for (int i = 0; i < NLEVEL; i++) begin
         sh_head[i]  = 0;
         sh_count[i] = 0;
      end
      sh_level      = 0;
      sh_quantum    = 0;
      sh_num_levels = mfq_pkg::NUM_LEVELS_RESET;
      sh_base       = mfq_pkg::QUANTUM_BASE_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_arrivals_and_overflow();
      test_newcomer_ahead();
      test_levels_out_of_use();
      test_config_extremes();
      test_random();
      drain();
      repeat (10) @(posedge clock);

      if (mismatches == 0 && stray_results == 0 && tick_outcomes.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
rtl/core/mfq_pkg.sv
rtl/core/mfq_ram.sv
rtl/core/mfq_pick.sv
rtl/core/multilevel_feedback_queue_scheduler.sv
rtl/core/mfq_checker.sv
tb/tb_top.sv
